>>> hdl/sorted_neighbor_list_replace_unit_assert.svh
// Assertion macros for the sorted neighbor list replace unit.
`ifndef SORTED_NEIGHBOR_LIST_REPLACE_UNIT_ASSERT_SVH
`define SORTED_NEIGHBOR_LIST_REPLACE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SNLR_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("snlr assertion failed");
// next-cycle implication
`define SNLR_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("snlr assertion failed");
`else
`define SNLR_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define SNLR_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

>>> hdl/snlr_pkg.sv
// Shared constants, codes and control types of the sorted neighbor list unit.
package snlr_pkg;

    localparam int NUM_VERTICES = 256;  // power of two, at most 256
    localparam int MAX_DEGREE   = 32;   // power of two

    localparam int VTX_W  = $clog2(NUM_VERTICES);
    localparam int DEG_W  = $clog2(MAX_DEGREE);
    localparam int LEN_W  = $clog2(MAX_DEGREE + 1);
    localparam int ADDR_W = VTX_W + DEG_W;

    localparam int FUNC_W   = 2;
    localparam int VID_W    = 8;
    localparam int POS_W    = 6;
    localparam int VAL_W    = 8;
    localparam int OLEN_W   = 6;
    localparam int STATUS_W = 2;
    localparam int CMP_W    = (LEN_W > POS_W) ? LEN_W : POS_W;

    localparam logic [FUNC_W-1:0] FN_APPEND  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REPLACE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_READ    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd2;

    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
    localparam logic [OP_W-1:0] OP_APPEND    = 4'd1;
    localparam logic [OP_W-1:0] OP_READ_POS  = 4'd2;
    localparam logic [OP_W-1:0] OP_START     = 4'd3;
    localparam logic [OP_W-1:0] OP_STEP      = 4'd4;
    localparam logic [OP_W-1:0] OP_PLACE     = 4'd5;
    localparam logic [OP_W-1:0] OP_JUMP      = 4'd6;
    localparam logic [OP_W-1:0] OP_SHRINK    = 4'd7;
    localparam logic [OP_W-1:0] OP_TAKE_READ = 4'd8;

    typedef struct packed {
        logic                in_load;
        logic                len_load;
        logic [STATUS_W-1:0] status;
        logic [OP_W-1:0]     op;
        logic                set_dup;
        logic                out_load;
    } cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              full;
        logic              pos_bad;
        logic              lt;
        logic              eq;
        logic              in_range;
        logic              dir_up;
    } stat_t;

endpackage

>>> hdl/snlr_datapath.sv
// Datapath: list memory, length store, walk index and result registers.
module snlr_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  snlr_pkg::cmd_t                 cmd,
    input  logic [snlr_pkg::FUNC_W-1:0]    in_func,
    input  logic [snlr_pkg::VID_W-1:0]     in_vertex_id,
    input  logic [snlr_pkg::POS_W-1:0]     in_position,
    input  logic [snlr_pkg::VAL_W-1:0]     in_new_value,
    output snlr_pkg::stat_t                stat,
    output logic [snlr_pkg::VAL_W-1:0]     read_value,
    output logic [snlr_pkg::OLEN_W-1:0]    list_length,
    output logic                           duplicate_removed,
    output logic [snlr_pkg::STATUS_W-1:0]  status
);
    import snlr_pkg::*;

    logic [VAL_W-1:0]  nb_mem [NUM_VERTICES*MAX_DEGREE];
    logic [LEN_W-1:0]  len_mem [NUM_VERTICES];
    logic              len_vld_reg [NUM_VERTICES];

    logic [FUNC_W-1:0] func_reg;
    logic [VTX_W-1:0]  vid_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_rd_reg;
    logic              len_vld_rd_reg;
    logic [VAL_W-1:0]  nb_rdata_reg;
    logic [LEN_W-1:0]  j_reg, j_next;
    logic              j_neg_reg, j_neg_next;
    logic              dir_up_reg, dir_up_next;

    logic [VAL_W-1:0]    res_read_reg;
    logic [LEN_W-1:0]    res_len_reg;
    logic                res_dup_reg;
    logic [STATUS_W-1:0] res_status_reg;

    logic [VAL_W-1:0]    out_read_reg;
    logic [LEN_W-1:0]    out_len_reg;
    logic                out_dup_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic [LEN_W-1:0]  len_cur;
    logic              lt, eq;
    logic              nb_we;
    logic [LEN_W-1:0]  wr_idx;
    logic [VAL_W-1:0]  wr_data;
    logic              len_we;
    logic [LEN_W-1:0]  len_wdata;

    assign len_cur = len_vld_rd_reg ? len_rd_reg : '0;
    assign lt      = val_reg < nb_rdata_reg;
    assign eq      = val_reg == nb_rdata_reg;

    assign stat.func     = func_reg;
    assign stat.full     = len_cur >= LEN_W'(MAX_DEGREE);
    assign stat.pos_bad  = (pos_reg == '0) || (CMP_W'(pos_reg) > CMP_W'(len_cur));
    assign stat.lt       = lt;
    assign stat.eq       = eq;
    assign stat.in_range = dir_up_reg ? (j_reg < len_reg) : !j_neg_reg;
    assign stat.dir_up   = dir_up_reg;

    // walk index: next entry to fetch
    always_comb
    begin
        j_next      = j_reg;
        j_neg_next  = j_neg_reg;
        dir_up_next = dir_up_reg;
        case (cmd.op)
            OP_READ_POS:
            begin
                j_next     = LEN_W'(pos_reg - POS_W'(1));
                j_neg_next = 1'b0;
            end
            OP_START:
            begin
                dir_up_next = lt;
                if (lt)
                begin
                    j_next     = j_reg + LEN_W'(1);
                    j_neg_next = 1'b0;
                end
                else
                begin
                    j_next     = j_reg - LEN_W'(1);
                    j_neg_next = (j_reg == '0);
                end
            end
            OP_STEP:
            begin
                if (dir_up_reg)
                begin
                    j_next = j_reg + LEN_W'(1);
                end
                else
                begin
                    j_next     = j_reg - LEN_W'(1);
                    j_neg_next = (j_reg == '0);
                end
            end
            OP_JUMP:
            begin
                // drop the entry above the match: slide the tail down from there
                j_next      = j_reg + LEN_W'(2);
                j_neg_next  = 1'b0;
                dir_up_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        nb_we   = (cmd.op == OP_STEP) || (cmd.op == OP_PLACE) || (cmd.op == OP_APPEND);
        wr_idx  = dir_up_reg ? (j_reg - LEN_W'(1)) : (j_reg + LEN_W'(1));
        wr_data = nb_rdata_reg;
        if (cmd.op == OP_APPEND)
        begin
            wr_idx = len_cur;
        end
        if ((cmd.op == OP_APPEND) || (cmd.op == OP_PLACE))
        begin
            wr_data = val_reg;
        end
        len_we    = (cmd.op == OP_APPEND) || (cmd.op == OP_SHRINK);
        len_wdata = (cmd.op == OP_APPEND) ? (len_cur + LEN_W'(1)) : (len_reg - LEN_W'(1));
    end

    always_ff @(posedge clk)
    begin
        nb_rdata_reg <= nb_mem[{vid_reg, j_next[DEG_W-1:0]}];
        if (nb_we)
        begin
            nb_mem[{vid_reg, wr_idx[DEG_W-1:0]}] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            len_rd_reg <= len_mem[in_vertex_id[VTX_W-1:0]];
        end
        if (len_we)
        begin
            len_mem[vid_reg] <= len_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_VERTICES; k++)
            begin
                len_vld_reg[k] <= 1'b0;
            end
            len_vld_rd_reg <= 1'b0;
        end
        else
        begin
            if (cmd.in_load)
            begin
                len_vld_rd_reg <= len_vld_reg[in_vertex_id[VTX_W-1:0]];
            end
            if (len_we)
            begin
                len_vld_reg[vid_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            func_reg <= in_func;
            vid_reg  <= in_vertex_id[VTX_W-1:0];
            pos_reg  <= in_position;
            val_reg  <= in_new_value;
        end
        if (cmd.len_load)
        begin
            len_reg        <= len_cur;
            res_len_reg    <= (cmd.op == OP_APPEND) ? len_wdata : len_cur;
            res_read_reg   <= '0;
            res_dup_reg    <= 1'b0;
            res_status_reg <= cmd.status;
        end
        else if (cmd.op == OP_SHRINK)
        begin
            res_len_reg <= len_wdata;
        end
        j_reg      <= j_next;
        j_neg_reg  <= j_neg_next;
        dir_up_reg <= dir_up_next;
        if (cmd.op == OP_TAKE_READ)
        begin
            res_read_reg <= nb_rdata_reg;
        end
        if (cmd.set_dup)
        begin
            res_dup_reg <= 1'b1;
        end
        if (cmd.out_load)
        begin
            out_read_reg   <= res_read_reg;
            out_len_reg    <= res_len_reg;
            out_dup_reg    <= res_dup_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign read_value        = out_read_reg;
    assign list_length       = OLEN_W'(out_len_reg);
    assign duplicate_removed = out_dup_reg;
    assign status            = out_status_reg;

endmodule

>>> hdl/snlr_ctrl.sv
// Controller: sequences length fetch, list walk, shift pass and result hand-off.
module snlr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  snlr_pkg::stat_t stat,
    output snlr_pkg::cmd_t  cmd
);
    import snlr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LEN   = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_RI    = 3'd3;
    localparam logic [2:0] S_WALK  = 3'd4;
    localparam logic [2:0] S_SHIFT = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.op     = OP_NONE;
        cmd.status = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.in_load = 1'b1;
                    state_next  = S_LEN;
                end
            end
            S_LEN:
            begin
                cmd.len_load = 1'b1;
                state_next   = S_DONE;
                unique case (stat.func) inside
                    FN_APPEND:
                    begin
                        if (stat.full)
                        begin
                            cmd.status = ST_FULL;
                        end
                        else
                        begin
                            cmd.op = OP_APPEND;
                        end
                    end
                    FN_REPLACE, FN_READ:
                    begin
                        if (stat.pos_bad)
                        begin
                            cmd.status = ST_BAD_POS;
                        end
                        else
                        begin
                            cmd.op     = OP_READ_POS;
                            state_next = (stat.func == FN_READ) ? S_RD : S_RI;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_RD:
            begin
                cmd.op     = OP_TAKE_READ;
                state_next = S_DONE;
            end
            S_RI:
            begin
                // pick direction from the replaced entry
                cmd.op     = OP_START;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (stat.dir_up)
                begin
                    if (stat.in_range && (stat.lt || stat.eq))
                    begin
                        cmd.op      = OP_STEP;
                        cmd.set_dup = stat.eq;
                        state_next  = stat.eq ? S_SHIFT : S_WALK;
                    end
                    else
                    begin
                        cmd.op     = OP_PLACE;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    if (stat.in_range && !stat.lt && !stat.eq)
                    begin
                        cmd.op = OP_STEP;
                    end
                    else if (stat.in_range && stat.eq)
                    begin
                        cmd.op      = OP_JUMP;
                        cmd.set_dup = 1'b1;
                        state_next  = S_SHIFT;
                    end
                    else
                    begin
                        cmd.op     = OP_PLACE;
                        state_next = S_DONE;
                    end
                end
            end
            S_SHIFT:
            begin
                if (stat.in_range)
                begin
                    cmd.op = OP_STEP;
                end
                else
                begin
                    cmd.op     = OP_SHRINK;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hdl/sorted_neighbor_list_replace_unit.sv
// Top level of the sorted neighbor list store with position replace.
//
//  channel  | direction | tdata (low bit up)                        | tuser
//  s_*      | in        | vertex_id 8, position 6, new_value 8, pad | func 2
//  m_*      | out       | read_value 8, list_length 6, dup 1, pad   | status 2
//
// One transaction in flight at a time; the next is taken once the result is in
// the output register. Replace also steps once per entry walked past or slid,
// plus once for a duplicate hit; one registered list read and one list write
// per cycle set its pace.
// Reset clears the length valid bits at once; no clearing pass is needed.
// A stalled result holds in the output register while the next transaction runs.
`include "sorted_neighbor_list_replace_unit_assert.svh"
module sorted_neighbor_list_replace_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // vertex_id[7:0], position[13:8], new_value[21:14]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // read_value[7:0], list_length[13:8], dup[14]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import snlr_pkg::*;

    cmd_t                cmd;
    stat_t               stat;
    logic [VAL_W-1:0]    read_value;
    logic [OLEN_W-1:0]   list_length;
    logic                duplicate_removed;
    logic [STATUS_W-1:0] status;

    snlr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    snlr_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .in_func           (s_tuser),
        .in_vertex_id      (s_tdata[7:0]),
        .in_position       (s_tdata[13:8]),
        .in_new_value      (s_tdata[21:14]),
        .stat              (stat),
        .read_value        (read_value),
        .list_length       (list_length),
        .duplicate_removed (duplicate_removed),
        .status            (status)
    );

    assign m_tdata = {1'b0, duplicate_removed, list_length, read_value};
    assign m_tuser = status;

    `SNLR_ASSERT_NXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `SNLR_ASSERT_IMP(a_dup_only_ok, clk, rst_n, m_tvalid && duplicate_removed, status == ST_OK)
    `SNLR_ASSERT_IMP(a_len_bound, clk, rst_n, m_tvalid, list_length <= OLEN_W'(MAX_DEGREE))
    `SNLR_ASSERT_IMP(a_err_no_data, clk, rst_n, m_tvalid && (status != ST_OK), read_value == '0)

endmodule
